// File: src/gpd_pkg.sv
// Shared types and constants for the GPIO port debouncer.
// No dependencies; used by gpio_port_debouncer_core.
package gpd_pkg;

    localparam int PIN_W       = 16;
    localparam int PORT_W      = 3;
    localparam int PORTS_DEF   = 8;
    localparam int WINDOW_DEF  = 4;
    // vote mode always looks at the newest four samples
    localparam int VOTE_DEPTH  = 4;

    typedef logic [PIN_W-1:0]  pins_t;
    typedef logic [PORT_W-1:0] port_t;

    // one raw sample request
    typedef struct packed {
        port_t port_sel;
        pins_t pin_sample;
    } in_t;

    // one debounced result
    typedef struct packed {
        port_t result_port;
        pins_t stable_pins;
    } out_t;

endpackage

// File: src/gpio_port_debouncer_core.sv
// Top level of the GPIO port debouncer: per-port sample history, stable
// words and a two-register request pipeline. Depends on gpd_pkg.
//
//  channel | ports                      | payload          | handshake
//  --------+----------------------------+------------------+--------------
//  input   | s_valid s_ready s_data     | gpd_pkg::in_t    | valid/ready
//  result  | m_valid m_ready m_data     | gpd_pkg::out_t   | valid/ready
//  config  | cfg_wr_en cfg_wr_data      | vote_mode bit    | write enable
//
// Each request passes through the input register and then the result
// register; one request per cycle is sustained while m_ready stays high.
// The history and stable word update happen in one pass of bitwise logic
// between those registers, so back-to-back requests to one port see fresh state.
// aresetn (synchronous) clears history, stable words, vote_mode and valids.
// A stalled result holds the pipeline; the input register still fills.
module gpio_port_debouncer_core #(
    parameter int PORTS  = gpd_pkg::PORTS_DEF,
    parameter int WINDOW = gpd_pkg::WINDOW_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gpd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gpd_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    typedef logic [WINDOW-1:0][gpd_pkg::PIN_W-1:0] hist_t;

    // state
    hist_t          hist_reg   [PORTS];
    gpd_pkg::pins_t stable_reg [PORTS];
    logic           vote_mode_reg;

    // pipeline registers
    logic           in_valid_reg;
    gpd_pkg::in_t   in_data_reg;
    logic           out_valid_reg;
    gpd_pkg::out_t  out_data_reg;

    logic           advance;
    logic           fire;
    logic           in_range;
    logic [IDX_W+2:0] port_ext;
    logic [IDX_W-1:0] idx;
    hist_t          hist_cur;
    hist_t          hist_next;
    gpd_pkg::pins_t stable_cur;
    gpd_pkg::pins_t stable_next;
    gpd_pkg::pins_t change;
    gpd_pkg::pins_t older_maj;

    // handshake
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // port lookup
    assign port_ext = {{IDX_W{1'b0}}, in_data_reg.port_sel};
    assign idx      = port_ext[IDX_W-1:0];
    assign in_range = 32'(in_data_reg.port_sel) < PORTS;

    // history shift (newest at entry 0) and stable word update
    always_comb begin
        hist_cur   = hist_reg[idx];
        stable_cur = stable_reg[idx];
        hist_next[0] = in_data_reg.pin_sample;
        for (int i = 1; i < WINDOW; i++) begin
            hist_next[i] = hist_cur[i-1];
        end
        // window: toggle only where every held sample disagrees
        change = '1;
        for (int i = 0; i < WINDOW; i++) begin
            change &= hist_next[i] ^ stable_cur;
        end
        // vote: newest sample plus majority of the three older ones
        older_maj = (hist_next[1] & hist_next[2]) | (hist_next[1] & hist_next[3])
                  | (hist_next[2] & hist_next[3]);
        if (vote_mode_reg) begin
            stable_next = (hist_next[0] & older_maj)
                        | (stable_cur & (hist_next[0] | older_maj));
        end else begin
            stable_next = stable_cur ^ change;
        end
    end

    // config, pipeline and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_mode_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PORTS; p++) begin
                hist_reg[p]   <= '0;
                stable_reg[p] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                vote_mode_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg            <= 1'b1;
                out_data_reg.result_port <= in_data_reg.port_sel;
                out_data_reg.stable_pins <= in_range ? stable_next : '0;
                if (in_range) begin
                    hist_reg[idx]   <= hist_next;
                    stable_reg[idx] <= stable_next;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // out-of-range ports report an all-zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (32'(m_data.result_port) >= PORTS) |-> m_data.stable_pins == '0)
        else $error("out-of-range port returned nonzero pins");

    // an accepted request lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request lost");

    // a request that leaves the input register becomes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid && m_data.result_port == $past(in_data_reg.port_sel))
        else $error("result missing after pipeline advance");

    // with no pending result the block always takes a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule
